### rtl/core/hwb62_pkg.sv
// ----------------------------------------------------------------------------
// hwb62_pkg
// types, op codes and the character table for the base-62 fingerprint block
// ----------------------------------------------------------------------------
package hwb62_pkg;

  localparam logic [1:0] OP_FIRST  = 2'd0;
  localparam logic [1:0] OP_NEXT   = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [63:0] DRAIN_LIMIT = 64'd130321;
  localparam int unsigned GROUP_W    = 6;
  localparam int unsigned LOW_W      = 48;
  localparam int unsigned CARRY_W    = 17;
  localparam int unsigned COUNT_W    = 6;
  localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(61);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] word_value;
  } in_word_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_in_run;
    logic       fingerprint_end;
  } out_word_t;

  typedef struct packed {
    logic        done;
    logic        is_char;
    logic        is_zero;
    logic        is_62;
    logic        is_63;
    logic [6:0]  code;
    logic [63:0] next_buf;
  } step_t;

  // symbol index to ascii over 0-9, A-Z, a-z, index taken modulo 62
  function automatic logic [6:0] sym_ascii(input logic [5:0] idx);
    logic [6:0] r;
    r = 7'd48;
    if (idx < 6'd10) begin
      r = 7'd48 + {1'b0, idx};
    end else if (idx < 6'd36) begin
      r = 7'd55 + {1'b0, idx};
    end else if (idx < 6'd62) begin
      r = 7'd61 + {1'b0, idx};
    end else begin
      r = 7'd48 + {1'b0, idx - 6'd62};
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] bump62(input logic [COUNT_W-1:0] c);
    return (c >= COUNT_TOP) ? '0 : c + COUNT_W'(1);
  endfunction

endpackage

### rtl/core/hwb62_step.sv
// ----------------------------------------------------------------------------
// hwb62_step
// shared group unit: loop test, 6-bit group decode and right shift by 6
// ----------------------------------------------------------------------------
module hwb62_step (
  input  logic                 finish_i,
  input  logic [63:0]          buf_i,
  output hwb62_pkg::step_t     step_o
);

  logic [5:0] grp;

  assign grp = buf_i[5:0];

  always_comb begin
    step_o.done     = finish_i ? (buf_i == 64'd0) : (buf_i <= hwb62_pkg::DRAIN_LIMIT);
    step_o.is_zero  = (grp == 6'd0);
    step_o.is_62    = (grp == 6'd62);
    step_o.is_63    = (grp == 6'd63);
    step_o.is_char  = !(step_o.is_zero || step_o.is_62 || step_o.is_63);
    step_o.code     = hwb62_pkg::sym_ascii(grp - 6'd1);
    step_o.next_buf = buf_i >> hwb62_pkg::GROUP_W;
  end

endmodule

### rtl/core/hex_word_to_base62_fingerprint_top.sv
// ----------------------------------------------------------------------------
// hex_word_to_base62_fingerprint_top
// binary words to base-62 fingerprint chars; unstalled, one 6-bit group a cycle
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_ready_o  | in_data_i  (op, word_value)
//  out     | out | out_valid_o/out_ready_i| out_data_o (char_code, last_in_run,
//          |     |                      |             fingerprint_end)
//
//  a word is accepted in idle, then the shared group unit takes its 6-bit
//  groups one at a time, then a closing step ends it: up to 8 groups for
//  first/next words, up to 11 for finish, which then sends any held character
//  and the 3 counter characters
//  in_ready_o is high only while the sequencer is idle
//  a stalled output register holds the sequencer when a character must go out
//  reset clears the control state at once, no clearing pass
// ----------------------------------------------------------------------------
module hex_word_to_base62_fingerprint_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hwb62_pkg::in_word_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hwb62_pkg::out_word_t  out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_COUNT = 3'b100
  } state_e;

  localparam int unsigned CW = hwb62_pkg::COUNT_W;

  state_e state_q, state_d;
  logic                           finish_q, finish_d;
  logic [63:0]                    buf_q, buf_d;
  logic [hwb62_pkg::CARRY_W-1:0]  carry_q, carry_d;
  logic [63:0]                    sum_q, sum_d;
  logic [CW-1:0]                  zc_q, zc_d, c62_q, c62_d, c63_q, c63_d;
  logic [1:0]                     idx_q, idx_d;
  logic                           pend_v_q, pend_v_d;
  logic [6:0]                     pend_q, pend_d;
  logic                           out_v_q, out_v_d;
  hwb62_pkg::out_word_t           out_q, out_d;

  hwb62_pkg::step_t step;
  logic             out_free;
  logic [63:0]      lo;
  logic [CW-1:0]    cnt_sel;

  hwb62_step u_step (
    .finish_i (finish_q),
    .buf_i    (buf_q),
    .step_o   (step)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_v_q || out_ready_i;
  assign lo          = {16'd0, in_data_i.word_value[hwb62_pkg::LOW_W-1:0]};

  always_comb begin
    case (idx_q)
      2'd0:    cnt_sel = zc_q;
      2'd1:    cnt_sel = c62_q;
      default: cnt_sel = c63_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    finish_d = finish_q;
    buf_d    = buf_q;
    carry_d  = carry_q;
    sum_d    = sum_q;
    zc_d     = zc_q;
    c62_d    = c62_q;
    c63_d    = c63_q;
    idx_d    = idx_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.op == hwb62_pkg::OP_FIRST) begin
            buf_d    = in_data_i.word_value;
            sum_d    = '0;
            zc_d     = '0;
            c62_d    = '0;
            c63_d    = '0;
            finish_d = 1'b0;
            state_d  = ST_DRAIN;
          end else if (in_data_i.op == hwb62_pkg::OP_NEXT) begin
            sum_d    = sum_q + lo;
            buf_d    = {carry_q[15:0], in_data_i.word_value[hwb62_pkg::LOW_W-1:0]};
            finish_d = 1'b0;
            state_d  = ST_DRAIN;
          end else if (in_data_i.op == hwb62_pkg::OP_FINISH) begin
            buf_d    = {{(64-hwb62_pkg::CARRY_W){1'b0}}, carry_q} + sum_q;
            finish_d = 1'b1;
            state_d  = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!step.done) begin
          if (!step.is_char) begin
            buf_d = step.next_buf;
            if (step.is_zero) zc_d = hwb62_pkg::bump62(zc_q);
            if (step.is_62)   c62_d = hwb62_pkg::bump62(c62_q);
            if (step.is_63)   c63_d = hwb62_pkg::bump62(c63_q);
          end else if (!pend_v_q || out_free) begin
            buf_d    = step.next_buf;
            pend_v_d = 1'b1;
            pend_d   = step.code;
            if (pend_v_q) begin
              out_v_d = 1'b1;
              out_d   = '{char_code: pend_q, last_in_run: 1'b0, fingerprint_end: 1'b0};
            end
          end
        end else if (finish_q) begin
          idx_d   = 2'd0;
          state_d = ST_COUNT;
        end else if (!pend_v_q || out_free) begin
          carry_d = buf_q[hwb62_pkg::CARRY_W-1:0];
          state_d = ST_IDLE;
          if (pend_v_q) begin
            pend_v_d = 1'b0;
            out_v_d  = 1'b1;
            out_d    = '{char_code: pend_q, last_in_run: 1'b1, fingerprint_end: 1'b0};
          end
        end
      end
      ST_COUNT: begin
        if (out_free) begin
          out_v_d = 1'b1;
          if (pend_v_q) begin
            pend_v_d = 1'b0;
            out_d    = '{char_code: pend_q, last_in_run: 1'b0, fingerprint_end: 1'b0};
          end else begin
            out_d = '{char_code: hwb62_pkg::sym_ascii(cnt_sel),
                      last_in_run: (idx_q == 2'd2), fingerprint_end: (idx_q == 2'd2)};
            idx_d = idx_q + 2'd1;
            if (idx_q == 2'd2) begin
              buf_d    = '0;
              carry_d  = '0;
              sum_d    = '0;
              zc_d     = '0;
              c62_d    = '0;
              c63_d    = '0;
              finish_d = 1'b0;
              state_d  = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      finish_q <= 1'b0;
      buf_q    <= '0;
      carry_q  <= '0;
      sum_q    <= '0;
      zc_q     <= '0;
      c62_q    <= '0;
      c63_q    <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      finish_q <= finish_d;
      buf_q    <= buf_d;
      carry_q  <= carry_d;
      sum_q    <= sum_d;
      zc_q     <= zc_d;
      c62_q    <= c62_d;
      c63_q    <= c63_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

endmodule

### test/hex_word_to_base62_fingerprint_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_word_to_base62_fingerprint_top_tb
// drives fingerprint word sequences (first, next, finish) through the block,
// predicts every fingerprint character from its own copy of the shift buffer,
// remainder, sum and counters, and checks each output word in order while
// both channels idle and stall at random across several phases
// ----------------------------------------------------------------------------
module hex_word_to_base62_fingerprint_top_tb;
  import hwb62_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  hex_word_to_base62_fingerprint_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #1 clk_i = ~clk_i;

  string alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  in_word_t  pending_words[$];
  out_word_t expected_chars[$];
  int        failures = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_seq = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  // fingerprint state of the predictor
  logic [63:0] fp_buffer = '0;
  logic [16:0] fp_rest = '0;
  logic [63:0] fp_sum = '0;
  logic [5:0]  cnt_zero = '0;
  logic [5:0]  cnt_62 = '0;
  logic [5:0]  cnt_63 = '0;

  function automatic logic [5:0] bump_count(input logic [5:0] c);
    return (c >= 6'd61) ? 6'd0 : c + 6'd1;
  endfunction

  function automatic out_word_t char_word(input int idx);
    out_word_t c;
    c = '0;
    c.char_code = 7'(alphabet[idx % 62]);
    return c;
  endfunction

  task automatic predict_chars(input in_word_t w);
    out_word_t run[$];
    out_word_t tmp;
    logic [5:0] v;
    logic finishing;
    finishing = (w.op == OP_FINISH);
    case (w.op)
      OP_FIRST: begin
        fp_buffer = w.word_value;
        fp_sum = '0;
        cnt_zero = '0;
        cnt_62 = '0;
        cnt_63 = '0;
      end
      OP_NEXT: begin
        fp_sum = fp_sum + {16'd0, w.word_value[47:0]};
        fp_buffer = {fp_rest[15:0], w.word_value[47:0]};
      end
      OP_FINISH: begin
        fp_buffer = {47'd0, fp_rest} + fp_sum;
      end
      default: return;
    endcase
    while (finishing ? (fp_buffer != 64'd0) : (fp_buffer > DRAIN_LIMIT)) begin
      v = fp_buffer[5:0];
      if (v == 6'd0) cnt_zero = bump_count(cnt_zero);
      else if (v == 6'd62) cnt_62 = bump_count(cnt_62);
      else if (v == 6'd63) cnt_63 = bump_count(cnt_63);
      else run.push_back(char_word(int'(v) - 1));
      fp_buffer = fp_buffer >> 6;
    end
    if (finishing) begin
      run.push_back(char_word(int'(cnt_zero)));
      run.push_back(char_word(int'(cnt_62)));
      tmp = char_word(int'(cnt_63));
      tmp.fingerprint_end = 1'b1;
      run.push_back(tmp);
      fp_buffer = '0;
      fp_rest = '0;
      fp_sum = '0;
      cnt_zero = '0;
      cnt_62 = '0;
      cnt_63 = '0;
    end else begin
      fp_rest = fp_buffer[16:0];
    end
    if (run.size() > 0) begin
      tmp = run.pop_back();
      tmp.last_in_run = 1'b1;
      run.push_back(tmp);
    end
    foreach (run[i]) expected_chars.push_back(run[i]);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) predict_chars(in_data);
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver with long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // checker
  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected word: char_code %0d", out_data.char_code);
        failures++;
      end else begin
        exp_w = expected_chars.pop_front();
        if (out_data.char_code !== exp_w.char_code) begin
          $error("char_code: expected %0d, actual %0d", exp_w.char_code, out_data.char_code);
          failures++;
        end
        if (out_data.last_in_run !== exp_w.last_in_run) begin
          $error("last_in_run: expected %0d, actual %0d",
                 exp_w.last_in_run, out_data.last_in_run);
          failures++;
        end
        if (out_data.fingerprint_end !== exp_w.fingerprint_end) begin
          $error("fingerprint_end: expected %0d, actual %0d",
                 exp_w.fingerprint_end, out_data.fingerprint_end);
          failures++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    logic [5:0] grp;
    case ($urandom_range(0, 5))
      0: w = {$urandom, $urandom};
      1: w = '1;
      2: w = 64'($urandom_range(0, 200000));
      default: begin
        w = '0;
        for (int g = 0; g < 11; g++) begin
          case ($urandom_range(0, 3))
            0: grp = 6'd0;
            1: grp = 6'd62;
            2: grp = 6'd63;
            default: grp = 6'($urandom);
          endcase
          w = (w << 6) | {58'd0, grp};
        end
      end
    endcase
    return w;
  endfunction

  task automatic add_word(input logic [1:0] op, input logic [63:0] value);
    in_word_t w;
    w.op = op;
    w.word_value = value;
    pending_words.push_back(w);
  endtask

  // mostly well formed fingerprints, with stray ops and broken sequences mixed in
  task automatic add_fingerprint();
    int n_next;
    n_next = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
    if ($urandom_range(0, 19) != 0) add_word(OP_FIRST, rand_word());
    for (int i = 0; i < n_next; i++) begin
      if ($urandom_range(0, 14) == 0) add_word(OP_UNUSED, rand_word());
      add_word(OP_NEXT, rand_word());
    end
    if ($urandom_range(0, 19) != 0) add_word(OP_FINISH, rand_word());
  endtask

  task automatic wait_idle();
    while (pending_words.size() > 0 || in_valid || expected_chars.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int n_items);
    int start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = pending_words.size();
    while (pending_words.size() - start < n_items) add_fingerprint();
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_word(OP_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_FINISH, 64'h0);
    add_word(OP_UNUSED, 64'hDEAD_BEEF_0123_4567);
    add_word(OP_FIRST, 64'h0);
    add_word(OP_NEXT, 64'h0);
    add_word(OP_FINISH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_FIRST, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_NEXT, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_NEXT, 64'hFFFF_0000_0000_0000);
    add_word(OP_FINISH, 64'h0);
    add_word(OP_FIRST, DRAIN_LIMIT);
    add_word(OP_FINISH, 64'h0);
    add_word(OP_FIRST, DRAIN_LIMIT + 64'd1);
    add_word(OP_NEXT, 64'h0000_0000_0001_0000);
    add_word(OP_FINISH, 64'h0);
    add_word(OP_FIRST, 64'h8000_0000_0000_0000);
    add_word(OP_NEXT, 64'h5555_AAAA_5555_AAAA);
    add_word(OP_FINISH, 64'h0);
    add_word(OP_FINISH, 64'h0);
    add_word(OP_FIRST, 64'hFBEF_BEFB_EFBE_FBEF);
    add_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(OP_NEXT, 64'h0000_F000_0FFF_0000);
    add_word(OP_FINISH, 64'h0);
    wait_idle();

    // receiver holds off while the sender keeps offering words
    for (int i = 0; i < 3; i++) add_fingerprint();
    hold_seq++;
    wait_idle();

    run_phase(0, 0, 45);
    run_phase(50, 0, 45);
    run_phase(0, 50, 45);
    run_phase(15, 15, 45);

    repeat (40) @(posedge clk_i);
    if (failures == 0 && expected_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("tb: failure");
    $finish;
  end

endmodule
